// ===== rtl/core/range_jump_hold_filter_core_macros.svh =====
// assertion macros for the range jump/hold filter core
// used by the port checker; no other dependencies
`ifndef RANGE_JUMP_HOLD_FILTER_CORE_MACROS_SVH
`define RANGE_JUMP_HOLD_FILTER_CORE_MACROS_SVH

// property checked only outside reset
`define RJHF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rjhf port check failed");

// property checked at every edge, reset included
`define RJHF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rjhf port check failed");

`endif

// ===== rtl/core/rjhf_pkg.sv =====
// shared types and constants for the range jump/hold filter core
// no dependencies
`timescale 1ns / 1ps

package rjhf_pkg;

   localparam int NFIELDS      = 3;
   localparam int RANGE_W      = 16;
   localparam int HOLD_W       = 9;
   localparam int MAX_HOLD_W   = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int CHANNELS_DEF = 3;

   localparam logic [RANGE_W-1:0] DEFAULT_MAX  = 16'd3000;
   localparam logic [RANGE_W-1:0] DEFAULT_STEP = 16'd50;
   localparam logic [RANGE_W-1:0] DEFAULT_RISE = 16'd500;
   localparam logic [MAX_HOLD_W-1:0] DEFAULT_HOLD = 8'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RANGE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RANGE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_ON      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RISE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_HOLD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_STEP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSETS      = 3'd6;

   // settings every lane sees, already sanitized
   typedef struct packed {
      logic [RANGE_W-1:0]    range_floor;
      logic [RANGE_W-1:0]    eff_max;
      logic                  jump_on;
      logic [RANGE_W-1:0]    max_rise;
      logic [MAX_HOLD_W-1:0] max_hold;
      logic [RANGE_W-1:0]    step;
   } cfg_type;

   typedef logic [NFIELDS-1:0][RANGE_W-1:0] field_vec_type;

endpackage

// ===== rtl/core/rjhf_lane.sv =====
// one channel of the range filter: offset, window, jump check, hold and release
// depends on rjhf_pkg
`timescale 1ns / 1ps

module rjhf_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [rjhf_pkg::RANGE_W-1:0]  raw,
   input  logic [rjhf_pkg::RANGE_W-1:0]  offset,
   input  rjhf_pkg::cfg_type             cfg,
   output logic [rjhf_pkg::RANGE_W-1:0]  range_out
);
   import rjhf_pkg::*;

   logic [RANGE_W-1:0]   prev_ff, prev_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;
   logic signed [17:0]   adj;
   logic signed [17:0]   rise;
   logic                 in_window;
   logic                 good;
   logic [HOLD_W-1:0]    hold_inc;
   logic [RANGE_W:0]     up_sum;
   logic [RANGE_W-1:0]   up;
   logic [RANGE_W-1:0]   filt;

   // 18-bit signed sum covers every raw/offset pair
   assign adj = $signed({2'b00, raw}) + $signed({{2{offset[RANGE_W-1]}}, offset});
   assign in_window = (adj >= $signed({2'b00, cfg.range_floor}))
                   && (adj <= $signed({2'b00, cfg.eff_max}));
   assign rise = adj - $signed({2'b00, prev_ff});
   assign good = in_window
              && !(cfg.jump_on && (prev_ff != '0) && (rise > $signed({2'b00, cfg.max_rise})));

   // hold count stops at max_hold + 1
   assign hold_inc = (hold_ff <= {1'b0, cfg.max_hold}) ? hold_ff + 1'b1 : hold_ff;

   assign up_sum = {1'b0, prev_ff} + {1'b0, cfg.step};
   assign up     = (up_sum > {1'b0, cfg.eff_max}) ? cfg.eff_max : up_sum[RANGE_W-1:0];

   always_comb begin
      prev_in = prev_ff;
      hold_in = hold_ff;
      filt    = cfg.eff_max;
      if (good) begin
         hold_in = '0;
         filt    = adj[RANGE_W-1:0];
         prev_in = adj[RANGE_W-1:0];
      end else if (prev_ff != '0) begin
         hold_in = hold_inc;
         if (hold_inc <= {1'b0, cfg.max_hold}) begin
            filt = prev_ff;
         end else begin
            filt    = up;
            prev_in = up;
         end
      end
   end

   assign range_out = ((filt <= cfg.range_floor) || (filt > cfg.eff_max)) ? cfg.eff_max : filt;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         hold_ff <= '0;
      end else if (accept) begin
         prev_ff <= prev_in;
         hold_ff <= hold_in;
      end
   end

endmodule

// ===== rtl/core/rjhf_merge.sv =====
// gathers lane results into one result item, with output register and skid entry
// depends on rjhf_pkg
`timescale 1ns / 1ps

module rjhf_merge #(
   parameter int LANES = rjhf_pkg::NFIELDS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_accept,
   input  logic [LANES-1:0][rjhf_pkg::RANGE_W-1:0] lane_range,
   input  logic [rjhf_pkg::RANGE_W-1:0]         eff_max,
   input  logic                                 out_stall,
   output logic                                 out_valid,
   output rjhf_pkg::field_vec_type              out_data,
   output logic                                 in_stall
);
   import rjhf_pkg::*;

   field_vec_type merged;
   field_vec_type out_data_ff;
   field_vec_type skid_data_ff;
   logic          out_valid_ff;
   logic          skid_valid_ff;
   logic          out_free;

   // fields without a lane read as the effective max
   for (genvar f = 0; f < NFIELDS; f++) begin : g_field
      if (f < LANES) begin : g_lane
         assign merged[f] = lane_range[f];
      end else begin : g_fill
         assign merged[f] = eff_max;
      end
   end

   assign out_free = !out_valid_ff || !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= in_accept;
         end
      end else if (in_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : merged;
      end else if (in_accept) begin
         skid_data_ff <= merged;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign in_stall  = skid_valid_ff;

endmodule

// ===== rtl/core/range_jump_hold_filter_core.sv =====
// range jump/hold filter: one result item per input item, one item per cycle unless held by rsp_stall
// the lanes are combinational; the merged result goes into the output register, or into the
// skid entry while the output register holds a stalled result
// a skid entry lets one more item in while a result waits on rsp_stall
// synchronous active-high reset restores register defaults and clears lane state
// depends on rjhf_pkg, rjhf_lane, rjhf_merge
`timescale 1ns / 1ps

module range_jump_hold_filter_core #(
   parameter int CHANNELS = rjhf_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rjhf_pkg::RANGE_W-1:0]    req_raw_right,
   input  logic [rjhf_pkg::RANGE_W-1:0]    req_raw_front,
   input  logic [rjhf_pkg::RANGE_W-1:0]    req_raw_left,
   // result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rjhf_pkg::RANGE_W-1:0]    rsp_range_right,
   output logic [rjhf_pkg::RANGE_W-1:0]    rsp_range_front,
   output logic [rjhf_pkg::RANGE_W-1:0]    rsp_range_left,
   // register writes
   input  logic                            csr_write,
   input  logic [rjhf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rjhf_pkg::CSR_DATA_W-1:0] csr_data
);
   import rjhf_pkg::*;

   // only channels that have a field get a lane
   localparam int LANES = (CHANNELS < NFIELDS) ? CHANNELS : NFIELDS;

   logic [RANGE_W-1:0]    range_floor_ff;
   logic [RANGE_W-1:0]    max_range_ff;
   logic                  jump_on_ff;
   logic [RANGE_W-1:0]    max_rise_ff;
   logic [MAX_HOLD_W-1:0] max_hold_ff;
   logic [RANGE_W-1:0]    release_step_ff;
   logic [CSR_DATA_W-1:0] offsets_ff;

   cfg_type                       cfg;
   field_vec_type                 raw_vec;
   field_vec_type                 rsp_vec;
   logic [LANES-1:0][RANGE_W-1:0] lane_range;
   logic                          req_accept;

   // register file; writes must come only while the block is idle (the block does not enforce this)
   always_ff @(posedge clock) begin
      if (reset) begin
         range_floor_ff  <= '0;
         max_range_ff    <= DEFAULT_MAX;
         jump_on_ff      <= 1'b1;
         max_rise_ff     <= DEFAULT_RISE;
         max_hold_ff     <= DEFAULT_HOLD;
         release_step_ff <= DEFAULT_STEP;
         offsets_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MIN_RANGE:    range_floor_ff  <= csr_data[RANGE_W-1:0];
            REG_MAX_RANGE:    max_range_ff    <= csr_data[RANGE_W-1:0];
            REG_JUMP_ON:      jump_on_ff      <= csr_data[0];
            REG_MAX_RISE:     max_rise_ff     <= csr_data[RANGE_W-1:0];
            REG_MAX_HOLD:     max_hold_ff     <= csr_data[MAX_HOLD_W-1:0];
            REG_RELEASE_STEP: release_step_ff <= csr_data[RANGE_W-1:0];
            REG_OFFSETS:      offsets_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // sanitize at use: empty window falls back to default max, zero step to default step
   always_comb begin
      cfg.range_floor = range_floor_ff;
      cfg.eff_max     = (max_range_ff > range_floor_ff) ? max_range_ff : DEFAULT_MAX;
      cfg.jump_on     = jump_on_ff;
      cfg.max_rise    = max_rise_ff;
      cfg.max_hold    = max_hold_ff;
      cfg.step        = (release_step_ff != '0) ? release_step_ff : DEFAULT_STEP;
   end

   // lane state moves only on an accepted item
   assign req_accept = req_valid && !req_stall;

   assign raw_vec[0] = req_raw_right;
   assign raw_vec[1] = req_raw_front;
   assign raw_vec[2] = req_raw_left;

   for (genvar c = 0; c < LANES; c++) begin : g_lane
      rjhf_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .accept    (req_accept),
         .raw       (raw_vec[c]),
         .offset    (offsets_ff[RANGE_W*c +: RANGE_W]),
         .cfg       (cfg),
         .range_out (lane_range[c])
      );
   end

   // lane results merge into the output register, skid entry behind it
   rjhf_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (req_accept),
      .lane_range (lane_range),
      .eff_max    (cfg.eff_max),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_data   (rsp_vec),
      .in_stall   (req_stall)
   );

   assign rsp_range_right = rsp_vec[0];
   assign rsp_range_front = rsp_vec[1];
   assign rsp_range_left  = rsp_vec[2];

endmodule

// ===== rtl/core/rjhf_checker.sv =====
// port-level checks for the range filter core, bound to the top level
// depends on rjhf_pkg and range_jump_hold_filter_core_macros.svh
`timescale 1ns / 1ps
`include "range_jump_hold_filter_core_macros.svh"

module rjhf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rjhf_pkg::RANGE_W-1:0] rsp_range_right,
   input logic [rjhf_pkg::RANGE_W-1:0] rsp_range_front,
   input logic [rjhf_pkg::RANGE_W-1:0] rsp_range_left
);
   import rjhf_pkg::*;

   logic [3*RANGE_W-1:0] rsp_all;
   logic                 all_nonzero;

   assign rsp_all     = {rsp_range_left, rsp_range_front, rsp_range_right};
   assign all_nonzero = (rsp_range_right != '0) && (rsp_range_front != '0)
                     && (rsp_range_left != '0);

   // nothing survives reset
   `RJHF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

   // after an accepted item a result is always valid next cycle
   `RJHF_ASSERT(a_accept_gives_result, clock, reset, req_valid && !req_stall |=> rsp_valid)

   // input only backs up when a result is already waiting
   `RJHF_ASSERT(a_stall_needs_result, clock, reset, req_stall |-> rsp_valid)

   // a filtered range is never zero: low values read as the max
   `RJHF_ASSERT(a_nonzero_range, clock, reset, rsp_valid |-> all_nonzero)

   // a stalled result holds
   `RJHF_ASSERT(a_stalled_holds, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_all))

endmodule

bind range_jump_hold_filter_core rjhf_checker u_rjhf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_range_right (rsp_range_right),
   .rsp_range_front (rsp_range_front),
   .rsp_range_left  (rsp_range_left)
);
